FILE: hw/rtl/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types and constants for the array backed doubly linked list.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ST_W     = 3;

  localparam logic [IDX_W-1:0] NONE_IDX    = 7'd127;
  localparam logic [KEY_W-1:0] INVALID_KEY = 32'h7FFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_DEL_FIRST = 3'd2,
    CMD_DEL_LAST  = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_INS_LINK,
    S_INS_HEAD,
    S_WALK,
    S_UNLINK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  data;
  } key_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  data;
  } link_wr_t;

  // a link points at a real node only below the capacity
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return idx < IDX_W'(CAPACITY);
  endfunction

endpackage

FILE: hw/rtl/adll_ram.sv
// ----------------------------------------------------------------------------
// adll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module adll_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/adll_seq.sv
// ----------------------------------------------------------------------------
// adll_seq
// Command sequencer: free slot scan, list walk, link updates and result
// register for the linked list node store.
// ----------------------------------------------------------------------------
module adll_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               cmd_i,
  input  logic signed [31:0]       key_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [2:0]               status_o,
  output logic signed [31:0]       out_key_o,
  output logic                     out_valid_o,
  output logic                     last_o,
  output logic [adll_pkg::ADDR_W-1:0] rd_addr_o,
  input  logic [adll_pkg::KEY_W-1:0]  key_rdata_i,
  input  logic [adll_pkg::IDX_W-1:0]  next_rdata_i,
  input  logic [adll_pkg::IDX_W-1:0]  prev_rdata_i,
  output adll_pkg::key_wr_t        key_wr_o,
  output adll_pkg::link_wr_t       next_wr_o,
  output adll_pkg::link_wr_t       prev_wr_o
);
  import adll_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ADDR_W-1:0]  scan_q, scan_d;
  logic [ADDR_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  status_e            status_q, status_d;
  logic [CAPACITY-1:0] used_q, used_d;

  logic               res_valid_q, res_valid_d;
  logic [ST_W-1:0]    res_status_q, res_status_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic               res_kv_q, res_kv_d;
  logic               res_last_q, res_last_d;

  logic can_load;
  logic key_hit;
  logic next_ok;
  logic do_unlink;

  assign can_load = !res_valid_q || res_ready_i;
  assign key_hit  = key_rdata_i == key_q;
  assign next_ok  = idx_ok(next_rdata_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (cmd_q)
          CMD_INSERT: state_d = (key_q == INVALID_KEY) ? S_RESP : S_SCAN;
          CMD_DELETE: begin
            if (key_q == INVALID_KEY || !idx_ok(head_q)) state_d = S_RESP;
            else state_d = S_WALK;
          end
          CMD_DEL_FIRST: state_d = idx_ok(head_q) ? S_UNLINK : S_RESP;
          CMD_DEL_LAST:  state_d = idx_ok(tail_q) ? S_UNLINK : S_RESP;
          CMD_DUMP:      state_d = idx_ok(head_q) ? S_WALK : S_RESP;
          default:       state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (!used_q[scan_q]) state_d = S_INS_LINK;
        else if (scan_q == LAST_SLOT) state_d = S_RESP;
      end
      S_INS_LINK: state_d = S_INS_HEAD;
      S_INS_HEAD: state_d = S_RESP;
      S_WALK: begin
        if (cmd_q == CMD_DUMP) begin
          if (can_load && !next_ok) state_d = S_IDLE;
        end else if (key_hit || !next_ok) begin
          state_d = S_RESP;
        end
      end
      S_UNLINK: state_d = S_RESP;
      S_RESP: begin
        if (can_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    cmd_d        = cmd_q;
    key_d        = key_q;
    idx_d        = idx_q;
    scan_d       = scan_q;
    slot_d       = slot_q;
    head_d       = head_q;
    tail_d       = tail_q;
    status_d     = status_q;
    used_d       = used_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_kv_d     = res_kv_q;
    res_last_d   = res_last_q;
    rd_addr_o    = idx_q[ADDR_W-1:0];
    key_wr_o     = '0;
    next_wr_o    = '0;
    prev_wr_o    = '0;
    do_unlink    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          key_d = key_i;
        end
      end
      S_DECODE: begin
        scan_d    = '0;
        idx_d     = (cmd_q == CMD_DEL_LAST) ? tail_q : head_q;
        rd_addr_o = idx_d[ADDR_W-1:0];
        status_d  = ST_EMPTY;
        if ((cmd_q == CMD_INSERT || cmd_q == CMD_DELETE) && key_q == INVALID_KEY) begin
          status_d = ST_INVALID;
        end
      end
      S_SCAN: begin
        if (!used_q[scan_q]) begin
          slot_d = scan_q;
        end else if (scan_q == LAST_SLOT) begin
          status_d = ST_FULL;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_INS_LINK: begin
        key_wr_o       = '{en: 1'b1, addr: slot_q, data: key_q};
        next_wr_o      = '{en: 1'b1, addr: slot_q, data: head_q};
        prev_wr_o      = '{en: 1'b1, addr: slot_q, data: NONE_IDX};
        used_d[slot_q] = 1'b1;
      end
      S_INS_HEAD: begin
        if (idx_ok(head_q)) begin
          prev_wr_o = '{en: 1'b1, addr: head_q[ADDR_W-1:0], data: IDX_W'(slot_q)};
        end else begin
          tail_d = IDX_W'(slot_q);
        end
        head_d   = IDX_W'(slot_q);
        status_d = ST_OK;
      end
      S_WALK: begin
        if (cmd_q == CMD_DUMP) begin
          if (can_load) begin
            res_valid_d  = 1'b1;
            res_status_d = ST_OK;
            res_key_d    = key_rdata_i;
            res_kv_d     = 1'b1;
            res_last_d   = !next_ok;
            if (next_ok) begin
              idx_d     = next_rdata_i;
              rd_addr_o = next_rdata_i[ADDR_W-1:0];
            end
          end
        end else if (key_hit) begin
          do_unlink = 1'b1;
          status_d  = ST_OK;
        end else if (!next_ok) begin
          status_d = ST_NOT_FOUND;
        end else begin
          idx_d     = next_rdata_i;
          rd_addr_o = next_rdata_i[ADDR_W-1:0];
        end
      end
      S_UNLINK: begin
        do_unlink = 1'b1;
        status_d  = ST_OK;
      end
      S_RESP: begin
        if (can_load) begin
          res_valid_d  = 1'b1;
          res_status_d = status_q;
          res_key_d    = '0;
          res_kv_d     = 1'b0;
          res_last_d   = 1'b1;
        end
      end
      default: ;
    endcase

    // splice the node at idx_q out using its prev and next links
    if (do_unlink) begin
      if (idx_ok(prev_rdata_i)) begin
        next_wr_o = '{en: 1'b1, addr: prev_rdata_i[ADDR_W-1:0], data: next_rdata_i};
      end else begin
        head_d = next_rdata_i;
      end
      if (next_ok) begin
        prev_wr_o = '{en: 1'b1, addr: next_rdata_i[ADDR_W-1:0], data: prev_rdata_i};
      end else begin
        tail_d = prev_rdata_i;
      end
      used_d[idx_q[ADDR_W-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NONE_IDX;
      tail_q      <= NONE_IDX;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    scan_q       <= scan_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_kv_q     <= res_kv_d;
    res_last_q   <= res_last_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign out_key_o   = res_key_q;
  assign out_valid_o = res_kv_q;
  assign last_o      = res_last_q;

endmodule

FILE: hw/rtl/array_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list of signed keys in a fixed node store with insert,
// delete by key, delete first, delete last and dump.
//
//   channel  signals                              direction
//   request  in_valid_i/in_ready_o, cmd_i, key_i  in
//   result   res_valid_o/res_ready_i, status_o,   out
//            out_key_o, out_valid_o, last_o
//
// one request at a time, accepted and then decoded; insert scans the used bits
// for a free slot, delete by key walks from the head until the key matches or
// the list ends, delete first and delete last unlink the head or tail node, and
// dump walks from the head, one link memory read per cycle unless results stall.
// each result waits in the result register while res_ready_i is low.
// reset empties the list at once; the node memories need no clearing.
// ----------------------------------------------------------------------------
module array_doubly_linked_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] key_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_key_o,
  output logic               out_valid_o,
  output logic               last_o
);
  import adll_pkg::*;

  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  key_rdata;
  logic [IDX_W-1:0]  next_rdata;
  logic [IDX_W-1:0]  prev_rdata;
  key_wr_t           key_wr;
  link_wr_t          next_wr;
  link_wr_t          prev_wr;

  adll_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .status_o     (status_o),
    .out_key_o    (out_key_o),
    .out_valid_o  (out_valid_o),
    .last_o       (last_o),
    .rd_addr_o    (rd_addr),
    .key_rdata_i  (key_rdata),
    .next_rdata_i (next_rdata),
    .prev_rdata_i (prev_rdata),
    .key_wr_o     (key_wr),
    .next_wr_o    (next_wr),
    .prev_wr_o    (prev_wr)
  );

  adll_ram #(.Width(KEY_W), .Depth(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_wr.en),
    .waddr_i (key_wr.addr),
    .wdata_i (key_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  adll_ram #(.Width(IDX_W), .Depth(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_wr.en),
    .waddr_i (next_wr.addr),
    .wdata_i (next_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  adll_ram #(.Width(IDX_W), .Depth(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_wr.en),
    .waddr_i (prev_wr.addr),
    .wdata_i (prev_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

endmodule
